FILE: rtl/binary_to_decimal_point_text_macros.svh
// Assertion shorthands shared by the RTL; each expects clk and rst_n in scope.
`ifndef BINARY_TO_DECIMAL_POINT_TEXT_MACROS_SVH
`define BINARY_TO_DECIMAL_POINT_TEXT_MACROS_SVH

// Check prop in the same cycle whenever cond holds.
`define B2DT_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check prop in the cycle after cond holds.
`define B2DT_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: rtl/b2dt_pkg.sv
package b2dt_pkg;

    localparam int VALUE_BITS          = 32;
    localparam int DIGIT_WIDTH         = 4;
    localparam int CHAR_WIDTH          = 6;
    localparam int FRAC_DIGITS         = 2;
    localparam int DEFAULT_DIGIT_COUNT = 8;
    localparam int STEPS_PER_STAGE     = 4;
    localparam int DEC_HALF            = 5;
    localparam int DEC_BASE            = 10;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 6'd57;
    localparam logic [CHAR_WIDTH-1:0] CHAR_POINT = 6'd46;

    function automatic longint unsigned pow10(input int n);
        longint unsigned m;
        m = 64'd1;
        for (int k = 0; k < n; k++)
        begin
            m = m * 64'd10;
        end
        return m;
    endfunction

endpackage

FILE: rtl/b2dt_pipe.sv
module b2dt_pipe #(
    parameter int DIGIT_COUNT = b2dt_pkg::DEFAULT_DIGIT_COUNT
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic [b2dt_pkg::VALUE_BITS-1:0]                     value,
    input  logic                                                in_valid,
    output logic                                                in_ready,
    output logic                                                dig_valid,
    input  logic                                                dig_ready,
    output logic [DIGIT_COUNT-1:0][b2dt_pkg::DIGIT_WIDTH-1:0]   digits
);
    import b2dt_pkg::*;

    localparam int STAGES = VALUE_BITS / STEPS_PER_STAGE;
    localparam logic [63:0] MAX_SHOWN = 64'(pow10(DIGIT_COUNT) - 64'd1);

    typedef logic [DIGIT_COUNT-1:0][DIGIT_WIDTH-1:0] bcd_t;

    // One shift-and-correct step: every digit doubles, takes the carry from
    // the digit below, and drops ten when it was five or more.
    function automatic bcd_t dabble(input bcd_t bcd, input logic bit_in);
        bcd_t                   res;
        logic [DIGIT_COUNT-1:0] carry;
        logic [DIGIT_WIDTH:0]   twice;
        carry[0] = bit_in;
        for (int j = 0; j < DIGIT_COUNT - 1; j++)
        begin
            carry[j+1] = (bcd[j] >= DIGIT_WIDTH'(DEC_HALF));
        end
        for (int j = 0; j < DIGIT_COUNT; j++)
        begin
            twice = {bcd[j], carry[j]};
            if (bcd[j] >= DIGIT_WIDTH'(DEC_HALF))
            begin
                twice = twice - (DIGIT_WIDTH+1)'(DEC_BASE);
            end
            res[j] = twice[DIGIT_WIDTH-1:0];
        end
        return res;
    endfunction

    logic                  valid_reg   [0:STAGES];
    logic                  stage_ready [0:STAGES];
    logic [VALUE_BITS-1:0] bin_reg     [0:STAGES];
    logic [VALUE_BITS-1:0] bin_next    [0:STAGES];
    bcd_t                  bcd_reg     [1:STAGES];
    bcd_t                  bcd_next    [1:STAGES];
    bcd_t                  bcd_in      [1:STAGES];

    // Clamp values that do not fit in the digit row.
    always_comb
    begin
        if (64'(value) > MAX_SHOWN)
        begin
            bin_next[0] = MAX_SHOWN[VALUE_BITS-1:0];
        end
        else
        begin
            bin_next[0] = value;
        end
    end

    genvar s;
    generate
        for (s = 0; s <= STAGES; s++)
        begin : g_ready
            if (s == STAGES)
            begin : g_tail
                assign stage_ready[s] = !valid_reg[s] || dig_ready;
            end
            else
            begin : g_body
                assign stage_ready[s] = !valid_reg[s] || stage_ready[s+1];
            end
        end

        for (s = 1; s <= STAGES; s++)
        begin : g_stage
            if (s == 1)
            begin : g_first
                assign bcd_in[s] = '0;
            end
            else
            begin : g_rest
                assign bcd_in[s] = bcd_reg[s-1];
            end

            always_comb
            begin : p_steps
                logic [VALUE_BITS-1:0] bn;
                bcd_t                  cn;
                bn = bin_reg[s-1];
                cn = bcd_in[s];
                for (int k = 0; k < STEPS_PER_STAGE; k++)
                begin
                    cn = dabble(cn, bn[VALUE_BITS-1]);
                    bn = bn << 1;
                end
                bin_next[s] = bn;
                bcd_next[s] = cn;
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[s] && valid_reg[s-1])
                begin
                    bin_reg[s] <= bin_next[s];
                    bcd_reg[s] <= bcd_next[s];
                end
            end
        end

        for (s = 0; s <= STAGES; s++)
        begin : g_valid
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (stage_ready[s])
                begin
                    if (s == 0)
                    begin
                        valid_reg[s] <= in_valid;
                    end
                    else
                    begin
                        valid_reg[s] <= valid_reg[(s == 0) ? 0 : s-1];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (stage_ready[0] && in_valid)
        begin
            bin_reg[0] <= bin_next[0];
        end
    end

    assign in_ready  = stage_ready[0];
    assign dig_valid = valid_reg[STAGES];
    assign digits    = bcd_reg[STAGES];

endmodule

FILE: rtl/binary_to_decimal_point_text.sv
// Prints a 32-bit count of hundredths as decimal text, one ASCII character
// per output word: the integer digits with leading zeros dropped (at least
// one), a '.', then two fraction digits, the last of which has last set.
// Values beyond DIGIT_COUNT digits print as all nines. The conversion runs in
// a 9-stage pipeline (a clamp stage and eight stages of four shift-and-correct
// steps). Throughput is set by the character stream: a value prints as 4 to
// DIGIT_COUNT + 1 characters, and the next value's text follows its
// predecessor with no gap while out_ready stays high and its digits are ready.
`include "binary_to_decimal_point_text_macros.svh"

module binary_to_decimal_point_text #(
    parameter int DIGIT_COUNT = b2dt_pkg::DEFAULT_DIGIT_COUNT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [b2dt_pkg::VALUE_BITS-1:0]     value,
    input  logic                                in_valid,
    output logic                                in_ready,
    output logic [b2dt_pkg::CHAR_WIDTH-1:0]     character,
    output logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready
);
    import b2dt_pkg::*;

    localparam int SLOT_W = $clog2(DIGIT_COUNT + 1);
    localparam int IDX_W  = $clog2(DIGIT_COUNT);

    logic                                     dig_valid;
    logic                                     dig_ready;
    logic [DIGIT_COUNT-1:0][DIGIT_WIDTH-1:0]  digits;

    logic [DIGIT_COUNT-1:0][DIGIT_WIDTH-1:0]  digits_reg;
    logic                                     busy_reg, busy_next;
    logic [SLOT_W-1:0]                        slot_reg, slot_next;
    logic [SLOT_W-1:0]                        start_slot;
    logic [SLOT_W-1:0]                        sel_slot;
    logic [IDX_W-1:0]                         sel_idx;
    logic [CHAR_WIDTH-1:0]                    char_reg, char_next;
    logic                                     last_reg;
    logic                                     out_valid_reg;
    logic                                     out_load;
    logic                                     emit;
    logic                                     at_end;

    b2dt_pipe #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .dig_valid (dig_valid),
        .dig_ready (dig_ready),
        .digits    (digits)
    );

    // Slots count down: integer digits, then the point, then two fractions.
    // Slot k above the point shows digit k-1.
    always_comb
    begin
        start_slot = SLOT_W'(FRAC_DIGITS + 1);
        for (int j = FRAC_DIGITS; j < DIGIT_COUNT; j++)
        begin
            if (digits[j] != '0)
            begin
                start_slot = SLOT_W'(j + 1);
            end
        end
    end

    assign out_load  = !out_valid_reg || out_ready;
    assign emit      = busy_reg && out_load;
    assign at_end    = (slot_reg == '0);
    assign dig_ready = !busy_reg || (emit && at_end);

    always_comb
    begin
        if (slot_reg > SLOT_W'(FRAC_DIGITS))
        begin
            sel_slot = slot_reg - SLOT_W'(1);
        end
        else
        begin
            sel_slot = slot_reg;
        end
        sel_idx = sel_slot[IDX_W-1:0];
        if (slot_reg == SLOT_W'(FRAC_DIGITS))
        begin
            char_next = CHAR_POINT;
        end
        else
        begin
            char_next = CHAR_ZERO + CHAR_WIDTH'(digits_reg[sel_idx]);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        slot_next = slot_reg;
        if (emit)
        begin
            slot_next = slot_reg - SLOT_W'(1);
        end
        if (dig_ready)
        begin
            busy_next = dig_valid;
            if (dig_valid)
            begin
                slot_next = start_slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            slot_reg <= slot_next;
            if (out_load)
            begin
                out_valid_reg <= busy_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dig_ready && dig_valid)
        begin
            digits_reg <= digits;
        end
        if (emit)
        begin
            char_reg <= char_next;
            last_reg <= at_end;
        end
    end

    assign character = char_reg;
    assign last      = last_reg;
    assign out_valid = out_valid_reg;

    `B2DT_ASSERT_NEXT(a_last_tracks_slot, emit, last == $past(at_end), "last flag off its slot")
    `B2DT_ASSERT_NOW(a_char_legal, out_valid, (character == CHAR_POINT) || ((character >= CHAR_ZERO) && (character <= CHAR_NINE)), "illegal character")
    `B2DT_ASSERT_NOW(a_slot_range, busy_reg, slot_reg <= SLOT_W'(DIGIT_COUNT), "slot past top digit")

endmodule

FILE: dv/decimal_text_checker.sv
`timescale 1ns / 100ps

module decimal_text_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [b2dt_pkg::VALUE_BITS-1:0]     value,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [b2dt_pkg::CHAR_WIDTH-1:0]     character,
    input  logic                                last,
    input  logic                                out_valid,
    input  logic                                out_ready,
    output int                                  mismatches,
    output int                                  outstanding
);

    localparam int DIGITS = b2dt_pkg::DEFAULT_DIGIT_COUNT;

    typedef struct packed {
        logic [b2dt_pkg::CHAR_WIDTH-1:0] code;
        logic                            tail;
    } text_char_t;

    text_char_t expected_text[$];
    int         error_count = 0;

    // Append the characters that one value in hundredths prints as.
    function automatic void predict_text(input logic [b2dt_pkg::VALUE_BITS-1:0] v);
        longint unsigned rest;
        longint unsigned ceiling;
        logic [3:0]      dig [DIGITS];
        bit              started;
        text_char_t      c;
        ceiling = 64'd1;
        for (int k = 0; k < DIGITS; k++)
        begin
            ceiling = ceiling * 64'd10;
        end
        ceiling = ceiling - 64'd1;
        rest = 64'(v);
        // saturate anything that does not fit in the digit string
        if (rest > ceiling)
        begin
            rest = ceiling;
        end
        for (int j = 0; j < DIGITS; j++)
        begin
            dig[j] = 4'(rest % 64'd10);
            rest   = rest / 64'd10;
        end
        started = 1'b0;
        for (int j = DIGITS - 1; j >= b2dt_pkg::FRAC_DIGITS; j--)
        begin
            // drop leading zeros, but keep the units digit
            if (started || j == b2dt_pkg::FRAC_DIGITS || dig[j] != 4'd0)
            begin
                started = 1'b1;
                c.code  = b2dt_pkg::CHAR_ZERO + 6'(dig[j]);
                c.tail  = 1'b0;
                expected_text.push_back(c);
            end
        end
        c.code = b2dt_pkg::CHAR_POINT;
        c.tail = 1'b0;
        expected_text.push_back(c);
        c.code = b2dt_pkg::CHAR_ZERO + 6'(dig[1]);
        expected_text.push_back(c);
        c.code = b2dt_pkg::CHAR_ZERO + 6'(dig[0]);
        c.tail = 1'b1;
        expected_text.push_back(c);
    endfunction

    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n)
        begin
            // check the outgoing word first so a stray one is never matched
            // against a value taken in the same cycle
            if (out_valid && out_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected word, expected none, actual character %0d last %0b",
                             $time, character, last);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (character !== want.code)
                    begin
                        error_count++;
                        $display("%0t: character expected %0d actual %0d",
                                 $time, want.code, character);
                    end
                    if (last !== want.tail)
                    begin
                        error_count++;
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.tail, last);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                predict_text(value);
            end
        end
        mismatches  <= error_count;
        outstanding <= expected_text.size();
    end

endmodule

FILE: dv/binary_to_decimal_point_text_test.sv
`timescale 1ns / 100ps

module binary_to_decimal_point_text_test;

    localparam int RANDOM_VALUES = 430;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PERCENT  = 34;
    localparam int TAIL_CYCLES   = 40;

    localparam int CORNER_COUNT = 24;
    localparam logic [31:0] CORNERS [CORNER_COUNT] = '{
        32'd0, 32'd1, 32'd5, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101,
        32'd999, 32'd1000, 32'd1234, 32'd12345, 32'd9999999, 32'd10000000,
        32'd50000000, 32'd99999998, 32'd99999999, 32'd100000000, 32'd123456789,
        32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE, 32'hFFFF_FFFF
    };

    logic        clk;
    logic        rst_n     = 1'b0;
    logic [31:0] value     = '0;
    logic        in_valid  = 1'b0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic [b2dt_pkg::CHAR_WIDTH-1:0] character;
    logic        last;
    logic        out_valid;

    logic        calm         = 1'b0;
    logic        hold_off_req = 1'b0;
    logic        hold_off_done = 1'b0;
    int          mismatches;
    int          outstanding;
    int          cycles = 0;

    binary_to_decimal_point_text dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .character (character),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    decimal_text_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .character   (character),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("binary_to_decimal_point_text: mismatch");
        $finish;
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Offer one word; return at the edge where it is taken.
    task automatic send_value(input logic [31:0] v);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Drop valid and hold until every expected character has come out.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] v;
        int unsigned p;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < CORNER_COUNT; i++)
        begin
            send_value(CORNERS[i]);
        end
        drain();

        for (int i = 0; i < RANDOM_VALUES; i++)
        begin
            if (i == 100)
            begin
                hold_off_req <= 1'b1;
            end
            if (i == 250)
            begin
                calm <= 1'b1;
            end
            if (i == 330)
            begin
                calm <= 1'b0;
            end
            case ($urandom_range(0, 9))
                0: v = $urandom;
                1: v = $urandom_range(0, 999);
                2: v = $urandom_range(99999990, 100000010);
                3:
                begin
                    p = 1;
                    repeat ($urandom_range(0, 8)) p = p * 10;
                    v = p + $urandom_range(0, 2) - 1;
                end
                default: v = $urandom >> $urandom_range(5, 31);
            endcase
            send_value(v);
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("binary_to_decimal_point_text: match");
        end
        else
        begin
            $display("binary_to_decimal_point_text: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/b2dt_pkg.sv
rtl/b2dt_pipe.sv
rtl/binary_to_decimal_point_text.sv
dv/decimal_text_checker.sv
dv/binary_to_decimal_point_text_test.sv
